FILE: src/dnd_pkg.sv
package dnd_pkg;

    // Default sizes of the message store and of one output word.
    localparam int MSG_BYTES_DEF  = 512;
    localparam int WORD_BYTES_DEF = 8;

    // Length bytes with both top bits set start a compression pointer.
    localparam logic [7:0] PTR_MARK = 8'hc0;

    // Capacity register value after reset.
    localparam logic [8:0] CAP_RESET = 9'd256;

    // Input commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Decode completion codes.
    typedef enum logic [1:0] {
        DS_OK       = 2'd0,
        DS_PAST_END = 2'd1,
        DS_OUT_FULL = 2'd2,
        DS_BAD_PTR  = 2'd3
    } dec_status_t;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic [8:0] addr;
        logic [7:0] data_byte;
        logic [9:0] msg_len;
        logic [8:0] name_pos;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic        out_kind;
        logic [63:0] out_word;
        logic [3:0]  byte_count;
        logic [1:0]  status;
        logic [7:0]  name_bytes;
        logic [9:0]  wire_len;
        logic        last;
    } out_item_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_RD,
        S_LEN,
        S_PTR,
        S_COPY,
        S_FLUSH,
        S_EMIT_RD,
        S_EMIT_LD,
        S_STATUS
    } ctl_state_t;

    // Store read address select.
    typedef enum logic {
        RD_POS,
        RD_POS1
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load_wr;
        logic        start;
        rd_sel_t     rd_sel;
        logic        latch_len;
        logic        take_len;
        logic        take_ptr;
        logic        term;
        logic        copy_byte;
        logic        flush;
        logic        emit_rd;
        logic        emit_ld;
        logic        status_ld;
        dec_status_t err_code;
    } dnd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_ptr;
        logic is_zero;
        logic past_end;
        logic ptr2_past;
        logic label_past;
        logic cap_full;
        logic bad_ptr;
        logic rem_last;
        logic emit_done;
        logic out_free;
    } dnd_stat_t;

endpackage

FILE: src/dns_name_decompressor.sv
// DNS name decompressor.
// Input beats on s_data (valid/ready) are either loads, which write one
// message byte into the store, or decodes, which walk the name at name_pos
// with msg_len as the end bound and follow compression pointers.
// A load writes the store and leaves the block idle and ready for the next beat.
// A decode reads each length byte, the second byte of each pointer and every
// label byte through the single store read port; on success it then closes the
// last word, reads the data words back from the word buffer one by one and loads
// the status beat. A decode accepts no new beat until its status beat is
// loaded into the output register.
// On success the data words come out on m_data, then one status beat with
// last set; on an error only the status beat comes out.
// The output register holds a beat while m_ready is low; the word readout
// and the status load wait for it, the label walk does not, and a new input
// beat is taken while the final status beat is still waiting.
// cfg_wr_en writes the capacity register cap_reg (reset value 256); write it only when idle.
// Reset (aresetn low, synchronous) returns to idle and empties the output;
// the message store keeps its contents and needs no clearing pass.
module dns_name_decompressor #(
    parameter int MSG_BYTES  = dnd_pkg::MSG_BYTES_DEF,
    parameter int WORD_BYTES = dnd_pkg::WORD_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dnd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dnd_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data
);
    import dnd_pkg::*;

    dnd_cmd_t  cmd;
    dnd_stat_t stat;

    dnd_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dnd_dp #(
        .MSG_BYTES  (MSG_BYTES),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

`ifndef SYNTHESIS
    // An accepted decode holds off further input beats on the next cycle.
    a_decode_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == CMD_DECODE |=> !s_ready)
        else $error("input accepted right after a decode started");

    // Only the status beat carries last.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.last == m_data.out_kind)
        else $error("last flag does not match the beat kind");

    // Data words carry between one and WORD_BYTES bytes.
    a_word_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_DATA |->
            m_data.byte_count != 4'd0 && m_data.byte_count <= 4'(WORD_BYTES))
        else $error("data word byte count out of range");

    // A failed decode reports no lengths.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_STATUS && m_data.status != DS_OK |->
            m_data.name_bytes == 8'd0 && m_data.wire_len == 10'd0)
        else $error("error status with nonzero lengths");
`endif

endmodule

FILE: src/dnd_ram.sv
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dnd_ctl.sv
module dnd_ctl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_cmd,
    output logic               s_ready,
    input  dnd_pkg::dnd_stat_t stat,
    output dnd_pkg::dnd_cmd_t  cmd
);
    import dnd_pkg::*;

    ctl_state_t  state_reg, state_next;
    dec_status_t code_reg, code_next;

    // State and completion code registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= DS_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_POS;
        cmd.err_code = code_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == CMD_DECODE) begin
                        cmd.start  = 1'b1;
                        code_next  = DS_OK;
                        state_next = S_LEN_RD;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end

            S_LEN_RD: begin
                if (stat.past_end) begin
                    code_next  = DS_PAST_END;
                    state_next = S_STATUS;
                end else begin
                    cmd.rd_sel = RD_POS;
                    state_next = S_LEN;
                end
            end

            // The length byte is on the store read port here.
            S_LEN: begin
                cmd.latch_len = 1'b1;
                cmd.rd_sel    = RD_POS1;
                priority if (stat.is_ptr) begin
                    if (stat.ptr2_past) begin
                        code_next  = DS_PAST_END;
                        state_next = S_STATUS;
                    end else begin
                        state_next = S_PTR;
                    end
                end else if (stat.is_zero) begin
                    cmd.term   = 1'b1;
                    state_next = S_FLUSH;
                end else if (stat.label_past) begin
                    code_next  = DS_PAST_END;
                    state_next = S_STATUS;
                end else if (stat.cap_full) begin
                    code_next  = DS_OUT_FULL;
                    state_next = S_STATUS;
                end else begin
                    cmd.take_len = 1'b1;
                    state_next   = S_COPY;
                end
            end

            // The second pointer byte is on the store read port here.
            S_PTR: begin
                if (stat.bad_ptr) begin
                    code_next  = DS_BAD_PTR;
                    state_next = S_STATUS;
                end else begin
                    cmd.take_ptr = 1'b1;
                    state_next   = S_LEN_RD;
                end
            end

            // One label byte per cycle, the next read issued alongside.
            S_COPY: begin
                cmd.copy_byte = 1'b1;
                cmd.rd_sel    = RD_POS1;
                if (stat.rem_last) begin
                    state_next = S_LEN_RD;
                end
            end

            S_FLUSH: begin
                cmd.flush  = 1'b1;
                state_next = S_EMIT_RD;
            end

            S_EMIT_RD: begin
                if (stat.emit_done) begin
                    state_next = S_STATUS;
                end else if (stat.out_free) begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_LD;
                end
            end

            S_EMIT_LD: begin
                cmd.emit_ld = 1'b1;
                state_next  = S_EMIT_RD;
            end

            S_STATUS: begin
                if (stat.out_free) begin
                    cmd.status_ld = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/dnd_dp.sv
module dnd_dp #(
    parameter int MSG_BYTES  = dnd_pkg::MSG_BYTES_DEF,
    parameter int WORD_BYTES = dnd_pkg::WORD_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dnd_pkg::in_item_t  s_data,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic               m_ready,
    output logic               m_valid,
    output dnd_pkg::out_item_t m_data,
    input  dnd_pkg::dnd_cmd_t  cmd,
    output dnd_pkg::dnd_stat_t stat
);
    import dnd_pkg::*;

    localparam int AW        = $clog2(MSG_BYTES);
    localparam int PW        = (AW + 1 > 10) ? AW + 1 : 10;
    localparam int CW        = (PW + 1 > 14) ? PW + 1 : 14;
    localparam int MAX_WORDS = (255 + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WAW       = $clog2(MAX_WORDS);
    localparam int NW        = $clog2(MAX_WORDS + 1);
    localparam int FW        = $clog2(WORD_BYTES + 1);
    localparam int LW        = 8 * WORD_BYTES;

    // Working registers of a decode.
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] end_reg, end_next;
    logic [8:0]    copied_reg, copied_next;
    logic [9:0]    wire_reg, wire_next;
    logic          jumped_reg, jumped_next;
    logic [7:0]    len_byte_reg, len_byte_next;
    logic [7:0]    rem_reg, rem_next;
    logic [LW-1:0] word_buf_reg, word_buf_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [NW-1:0] nwords_reg, nwords_next;
    logic [NW-1:0] k_reg, k_next;
    logic [3:0]    lastcnt_reg, lastcnt_next;
    logic [8:0]    cap_reg, cap_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    // Store and word buffer ports.
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_rdata;
    logic          wd_we;
    logic [LW-1:0] wd_wdata, wd_rdata;

    logic [PW-1:0] pos_plus1;
    logic [CW-1:0] pos_c, end_c, msg_c;
    logic [13:0]   tgt;
    logic [LW-1:0] buf_with;
    logic          push, wrap, room, last_word;

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_data.data_byte),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dnd_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WORDS)
    ) u_words (
        .aclk  (aclk),
        .we    (wd_we),
        .waddr (nwords_reg[WAW-1:0]),
        .wdata (wd_wdata),
        .raddr (k_reg[WAW-1:0]),
        .rdata (wd_rdata)
    );

    // Store access: loads write, the walk reads at the position or one past it.
    always_comb begin
        pos_plus1 = pos_reg + PW'(1);
        st_we     = cmd.load_wr && (CW'(s_data.addr) < CW'(MSG_BYTES));
        st_waddr  = AW'(s_data.addr);
        st_raddr  = (cmd.rd_sel == RD_POS) ? pos_reg[AW-1:0] : pos_plus1[AW-1:0];
    end

    // Bound, capacity and pointer checks, mostly on the read byte; readout end; output free.
    always_comb begin
        pos_c          = CW'(pos_reg);
        end_c          = CW'(end_reg);
        tgt            = {len_byte_reg[5:0], st_rdata};
        stat.is_ptr    = (st_rdata & PTR_MARK) == PTR_MARK;
        stat.is_zero   = st_rdata == 8'd0;
        stat.past_end  = pos_c >= end_c;
        stat.ptr2_past = (pos_c + CW'(1)) >= end_c;
        stat.label_past = (pos_c + CW'(st_rdata)) >= end_c;
        stat.cap_full  = ({1'b0, copied_reg} + {2'b00, st_rdata} + 10'd1) >= {1'b0, cap_reg};
        stat.bad_ptr   = CW'(tgt) >= pos_c;
        stat.rem_last  = rem_reg == 8'd1;
        stat.emit_done = k_reg == nwords_reg;
        stat.out_free  = !out_valid_reg || m_ready;
    end

    // Byte packing: the pushed byte lands in the lane the fill count names.
    always_comb begin
        push  = cmd.take_len || cmd.copy_byte;
        wrap  = fill_reg == FW'(WORD_BYTES - 1);
        room  = nwords_reg < NW'(MAX_WORDS);
        for (int i = 0; i < WORD_BYTES; i++) begin
            buf_with[8*i +: 8] = (fill_reg == FW'(i)) ? st_rdata : word_buf_reg[8*i +: 8];
        end
        wd_we    = room && ((push && wrap) || (cmd.flush && fill_reg != '0));
        wd_wdata = cmd.flush ? word_buf_reg : buf_with;
    end

    // Next values of the working registers.
    always_comb begin
        pos_next       = pos_reg;
        end_next       = end_reg;
        copied_next    = copied_reg;
        wire_next      = wire_reg;
        jumped_next    = jumped_reg;
        len_byte_next  = len_byte_reg;
        rem_next       = rem_reg;
        word_buf_next  = word_buf_reg;
        fill_next      = fill_reg;
        nwords_next    = nwords_reg;
        k_next         = k_reg;
        lastcnt_next   = lastcnt_reg;
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        msg_c          = CW'(s_data.msg_len);
        last_word      = (NW + 1)'(k_reg) + (NW + 1)'(1) == (NW + 1)'(nwords_reg);

        // A decode starts with cleared counters and a clamped end bound.
        if (cmd.start) begin
            end_next     = (msg_c > CW'(MSG_BYTES)) ? PW'(MSG_BYTES) : PW'(msg_c);
            pos_next     = PW'(s_data.name_pos);
            copied_next  = '0;
            wire_next    = '0;
            jumped_next  = 1'b0;
            word_buf_next = '0;
            fill_next    = '0;
            nwords_next  = '0;
        end

        if (cmd.latch_len) begin
            len_byte_next = st_rdata;
        end

        // Wire length counts only the part of the name up to and including the first pointer.
        if (cmd.take_len) begin
            rem_next = st_rdata;
            if (!jumped_reg) begin
                wire_next = wire_reg + 10'(st_rdata) + 10'd1;
            end
        end
        if (cmd.copy_byte) begin
            rem_next = rem_reg - 8'd1;
        end
        if (cmd.term && !jumped_reg) begin
            wire_next = wire_reg + 10'd1;
        end
        if (cmd.take_ptr) begin
            pos_next    = PW'(tgt);
            jumped_next = 1'b1;
            if (!jumped_reg) begin
                wire_next = wire_reg + 10'd2;
            end
        end

        // Each pushed byte advances the position and fills the word buffer.
        if (push) begin
            pos_next    = pos_plus1;
            copied_next = copied_reg + 9'd1;
            if (wrap) begin
                word_buf_next = '0;
                fill_next     = '0;
                if (room) begin
                    nwords_next = nwords_reg + NW'(1);
                end
            end else begin
                word_buf_next = buf_with;
                fill_next     = fill_reg + FW'(1);
            end
        end

        // A partial word closes the name; its byte count is kept for the last word.
        if (cmd.flush) begin
            k_next       = '0;
            lastcnt_next = 4'(fill_reg);
            if (fill_reg != '0 && room) begin
                nwords_next = nwords_reg + NW'(1);
            end
        end

        // Output register loads.
        if (cmd.emit_ld) begin
            out_valid_next            = 1'b1;
            out_data_next             = '0;
            out_data_next.out_kind    = KIND_DATA;
            out_data_next.out_word    = 64'(wd_rdata);
            out_data_next.byte_count  = (last_word && lastcnt_reg != 4'd0) ?
                                        lastcnt_reg : 4'(WORD_BYTES);
            k_next                    = k_reg + NW'(1);
        end
        if (cmd.status_ld) begin
            out_valid_next            = 1'b1;
            out_data_next             = '0;
            out_data_next.out_kind    = KIND_STATUS;
            out_data_next.status      = cmd.err_code;
            out_data_next.name_bytes  = (cmd.err_code == DS_OK) ? copied_reg[7:0] : 8'd0;
            out_data_next.wire_len    = (cmd.err_code == DS_OK) ? wire_reg : 10'd0;
            out_data_next.last        = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        end_reg      <= end_next;
        copied_reg   <= copied_next;
        wire_reg     <= wire_next;
        jumped_reg   <= jumped_next;
        len_byte_reg <= len_byte_next;
        rem_reg      <= rem_next;
        word_buf_reg <= word_buf_next;
        fill_reg     <= fill_next;
        nwords_reg   <= nwords_next;
        k_reg        <= k_next;
        lastcnt_reg  <= lastcnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
